FILE: src/assert_macros.svh
// Concurrent assertion wrappers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_AR(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
        else $error("assertion failed");

`define ASSERT_ALWAYS(lbl, clk_s, prop) \
    lbl: assert property (@(posedge clk_s) prop) \
        else $error("assertion failed");

`else

`define ASSERT_AR(lbl, clk_s, rstn_s, prop)

`define ASSERT_ALWAYS(lbl, clk_s, prop)

`endif

`endif

FILE: src/spq_pkg.sv
package spq_pkg;

    typedef struct packed {
        logic [15:0] run_time;
        logic [7:0]  prio_level;
        logic [15:0] task_id;
    } entry_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_REMOVED  = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef struct packed {
        logic ins;
        logic rem;
    } cell_cmd_t;

    typedef struct packed {
        entry_t ent;
        logic   valid;
        logic   keep;
    } cell_link_t;

endpackage

FILE: src/spq_cell.sv
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_cmd_t  cmd,
    input  entry_t     new_entry,
    input  cell_link_t left_link,
    input  cell_link_t right_link,
    output cell_link_t link
);

    entry_t ent_reg;
    entry_t ent_next;
    logic   valid_reg;
    logic   valid_next;
    logic   keep;

    assign keep = valid_reg && (ent_reg.prio_level <= new_entry.prio_level);

    always_comb
    begin
        ent_next   = ent_reg;
        valid_next = valid_reg;
        if (cmd.ins)
        begin
            if (!keep)
            begin
                if (left_link.keep)
                begin
                    ent_next   = new_entry;
                    valid_next = 1'b1;
                end
                else
                begin
                    ent_next   = left_link.ent;
                    valid_next = left_link.valid;
                end
            end
        end
        else if (cmd.rem)
        begin
            ent_next   = right_link.ent;
            valid_next = right_link.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign link.ent   = ent_reg;
    assign link.valid = valid_reg;
    assign link.keep  = keep;

endmodule

FILE: src/sorted_priority_queue.sv
// Channel | Direction | Signals                               | Content
// s_      | in        | s_tvalid s_tready s_tdata s_tuser     | request item
// m_      | out       | m_tvalid m_tready m_tdata m_tuser     | result item
//
// For each request item, every cell compares against the new priority and
// shifts at once, so one item is accepted per cycle while the result
// register is free or being drained.
// Reset clears the cell valid bits and the count; cell payloads are not reset.
// A stall on m_ holds the result and blocks s_ until the result is taken.
`include "assert_macros.svh"

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // task_id[15:0], prio_level[23:16], run_time[39:24]
    input  logic [0:0]  s_tuser,   // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_task_id[15:0], out_prio_level[23:16],
                                   // out_run_time[39:24], fill_count[45:40], zero[47:46]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                   s_acc;
    entry_t                 new_entry;
    cell_cmd_t              cmd;
    cell_link_t             links [QUEUE_DEPTH];
    cell_link_t             head_link;
    cell_link_t             tail_link;
    logic [QUEUE_DEPTH-1:0] valid_vec;
    logic                   full;
    logic                   empty;
    logic                   is_remove;

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [CW+5:0]          count_wide;

    logic                   m_valid_reg;
    logic                   m_valid_next;
    status_t                status_reg;
    status_t                status_next;
    entry_t                 out_ent_reg;
    entry_t                 out_ent_next;
    logic [5:0]             fill_reg;
    logic [5:0]             fill_next;

    assign s_tready  = !m_valid_reg || m_tready;
    assign s_acc     = s_tvalid && s_tready;
    assign new_entry = '{run_time: s_tdata[39:24], prio_level: s_tdata[23:16],
                         task_id: s_tdata[15:0]};
    assign is_remove = (s_tuser[0] == REQ_REMOVE);

    assign full  = links[QUEUE_DEPTH-1].valid;
    assign empty = !links[0].valid;

    assign cmd.ins = s_acc && !is_remove && !full;
    assign cmd.rem = s_acc && is_remove && !empty;

    assign head_link = '{ent: new_entry, valid: 1'b1, keep: 1'b1};
    assign tail_link = '{ent: new_entry, valid: 1'b0, keep: 1'b0};

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            cell_link_t left_in;
            cell_link_t right_in;

            if (gi == 0)
            begin : g_first
                assign left_in = head_link;
            end
            else
            begin : g_mid_l
                assign left_in = links[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_in = tail_link;
            end
            else
            begin : g_mid_r
                assign right_in = links[gi+1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .new_entry  (new_entry),
                .left_link  (left_in),
                .right_link (right_in),
                .link       (links[gi])
            );

            assign valid_vec[gi] = links[gi].valid;
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + {{(CW-1){1'b0}}, 1'b1};
        end
        else if (cmd.rem)
        begin
            count_next = count_reg - {{(CW-1){1'b0}}, 1'b1};
        end
    end

    assign count_wide = {6'd0, count_next};
    assign fill_next  = count_wide[5:0];

    always_comb
    begin
        out_ent_next = '0;
        if (!is_remove)
        begin
            status_next = full ? ST_FULL : ST_INSERTED;
        end
        else if (empty)
        begin
            status_next = ST_EMPTY;
        end
        else
        begin
            status_next  = ST_REMOVED;
            out_ent_next = links[0].ent;
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (s_acc)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            status_reg  <= status_next;
            out_ent_reg <= out_ent_next;
            fill_reg    <= fill_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {2'b00, fill_reg, out_ent_reg.run_time, out_ent_reg.prio_level,
                       out_ent_reg.task_id};

    `ASSERT_AR(a_valid_contig, clk, rst_n, ((valid_vec >> 1) & ~valid_vec) == '0)
    `ASSERT_AR(a_count_match, clk, rst_n, $countones(valid_vec) == count_reg)
    `ASSERT_AR(a_ins_grow, clk, rst_n, cmd.ins |=> count_reg == $past(count_reg) + 1'b1)
    `ASSERT_AR(a_rem_head, clk, rst_n,
        cmd.rem |=> m_tdata[23:16] <= links[0].ent.prio_level || !links[0].valid)
    `ASSERT_ALWAYS(a_empty_zero, clk,
        (rst_n && m_tvalid && m_tuser == ST_EMPTY) |-> m_tdata[45:0] == '0)

endmodule

FILE: sim/tb_sorted_priority_queue.sv
`timescale 1ns / 100ps

module tb_sorted_priority_queue
    import spq_pkg::*;
();

    localparam int QDEPTH      = 32;
    localparam int TAIL_ITEMS  = 150;
    localparam int HOLD_START  = 1000;
    localparam int HOLD_CYCLES = 250;

    typedef struct {
        logic   req;
        entry_t ent;
    } request_t;

    typedef struct {
        status_t    status;
        entry_t     ent;
        logic [5:0] fill;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    request_t pending[$];
    outcome_t expected_outcomes[$];

    entry_t   sorted_entries[QDEPTH];
    int       stored_count = 0;

    request_t offered;
    int       tx_gap = 0;
    bit       tx_bursty = 1'b1;
    int       rx_gap = 0;
    bit       rx_bursty = 1'b1;
    int       rx_cycle = 0;
    int       hold_left = 0;

    int       fails = 0;
    int       requests_sent = 0;
    int       n_inserted = 0;
    int       n_refused = 0;
    int       n_removed = 0;
    int       n_empty = 0;
    int       peak_fill = 0;

    sorted_priority_queue #(.QUEUE_DEPTH(QDEPTH)) u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic outcome_t apply_request(request_t r);
        outcome_t o;
        int       k;
        o.status = ST_INSERTED;
        o.ent    = '0;
        if (r.req == REQ_INSERT)
        begin
            if (stored_count >= QDEPTH)
            begin
                o.status = ST_FULL;
            end
            else
            begin
                k = stored_count;
                while (k > 0 && sorted_entries[k - 1].prio_level > r.ent.prio_level)
                begin
                    sorted_entries[k] = sorted_entries[k - 1];
                    k--;
                end
                sorted_entries[k] = r.ent;
                stored_count++;
            end
        end
        else if (stored_count == 0)
        begin
            o.status = ST_EMPTY;
        end
        else
        begin
            o.ent    = sorted_entries[0];
            for (k = 1; k < stored_count; k++)
            begin
                sorted_entries[k - 1] = sorted_entries[k];
            end
            stored_count--;
            o.status = ST_REMOVED;
        end
        o.fill = stored_count[5:0];
        return o;
    endfunction

    function automatic request_t make_request(logic req, logic [15:0] id,
                                              logic [7:0] prio, logic [15:0] rt);
        request_t r;
        r.req            = req;
        r.ent.task_id    = id;
        r.ent.prio_level = prio;
        r.ent.run_time   = rt;
        return r;
    endfunction

    function automatic logic [7:0] pick_priority();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 3));
            1:       return 8'($urandom_range(252, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // driver
    always @(posedge clk)
    begin
        logic nv;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_outcomes.push_back(apply_request(offered));
                requests_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if ($urandom_range(0, 99) == 0)
                    tx_bursty = !tx_bursty;
                nv = 1'b0;
                if (tx_gap != 0)
                begin
                    tx_gap--;
                end
                else if (tx_bursty && pending.size() > TAIL_ITEMS &&
                         $urandom_range(0, 7) == 0)
                begin
                    tx_gap = int'($urandom_range(1, 10)) - 1;
                end
                else if (pending.size() != 0)
                begin
                    offered = pending.pop_front();
                    nv = 1'b1;
                end
                s_tvalid <= nv;
                if (nv)
                begin
                    s_tdata <= offered.ent;
                    s_tuser <= offered.req;
                end
            end
        end
    end

    // receiver with one long hold-off
    always @(posedge clk)
    begin
        logic rdy;
        if (rst_n)
        begin
            rx_cycle++;
            if ($urandom_range(0, 99) == 0)
                rx_bursty = !rx_bursty;
            rdy = 1'b0;
            if (hold_left != 0)
            begin
                hold_left--;
            end
            else if (rx_cycle == HOLD_START)
            begin
                hold_left = HOLD_CYCLES - 1;
            end
            else if (rx_gap != 0)
            begin
                rx_gap--;
            end
            else if (rx_bursty && pending.size() > TAIL_ITEMS &&
                     $urandom_range(0, 7) == 0)
            begin
                rx_gap = int'($urandom_range(1, 10)) - 1;
            end
            else
            begin
                rdy = 1'b1;
            end
            m_tready <= rdy;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $error("result with no request outstanding: status %0d", m_tuser);
                fails++;
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (m_tuser !== want.status)
                begin
                    $error("status exp %0d act %0d", want.status, m_tuser);
                    fails++;
                end
                if (m_tdata[15:0] !== want.ent.task_id)
                begin
                    $error("out_task_id exp %0h act %0h", want.ent.task_id, m_tdata[15:0]);
                    fails++;
                end
                if (m_tdata[23:16] !== want.ent.prio_level)
                begin
                    $error("out_prio_level exp %0h act %0h", want.ent.prio_level,
                           m_tdata[23:16]);
                    fails++;
                end
                if (m_tdata[39:24] !== want.ent.run_time)
                begin
                    $error("out_run_time exp %0h act %0h", want.ent.run_time,
                           m_tdata[39:24]);
                    fails++;
                end
                if (m_tdata[45:40] !== want.fill)
                begin
                    $error("fill_count exp %0d act %0d", want.fill, m_tdata[45:40]);
                    fails++;
                end
                case (want.status)
                    ST_INSERTED: n_inserted++;
                    ST_FULL:     n_refused++;
                    ST_REMOVED:  n_removed++;
                    ST_EMPTY:    n_empty++;
                endcase
                if (int'(want.fill) > peak_fill)
                    peak_fill = int'(want.fill);
            end
        end
    end

    initial
    begin
        int insert_pct;
        int run_len;
        int phase;

        pending.push_back(make_request(REQ_REMOVE, 16'h0000, 8'h00, 16'h0000));
        pending.push_back(make_request(REQ_INSERT, 16'hFFFF, 8'hFF, 16'hFFFF));
        pending.push_back(make_request(REQ_INSERT, 16'h0000, 8'h00, 16'h0000));
        pending.push_back(make_request(REQ_INSERT, 16'h0001, 8'h80, 16'h1234));
        pending.push_back(make_request(REQ_INSERT, 16'h0002, 8'h80, 16'h5678));
        pending.push_back(make_request(REQ_INSERT, 16'h0003, 8'h80, 16'h9ABC));
        pending.push_back(make_request(REQ_INSERT, 16'h0004, 8'hFF, 16'h0001));
        pending.push_back(make_request(REQ_INSERT, 16'h0005, 8'h00, 16'h8000));
        repeat (8)
            pending.push_back(make_request(REQ_REMOVE, 16'hFFFF, 8'hFF, 16'hFFFF));
        pending.push_back(make_request(REQ_INSERT, 16'hA5A5, 8'h7F, 16'h5A5A));
        pending.push_back(make_request(REQ_REMOVE, 16'h0000, 8'h00, 16'h0000));

        // alternate fill, churn and drain phases
        phase = 0;
        while (pending.size() < 1800)
        begin
            case (phase % 3)
                0:       insert_pct = 90;
                1:       insert_pct = 50;
                default: insert_pct = 10;
            endcase
            run_len = $urandom_range(50, 90);
            repeat (run_len)
            begin
                pending.push_back(make_request(
                    ($urandom_range(1, 100) <= insert_pct) ? REQ_INSERT : REQ_REMOVE,
                    16'($urandom), pick_priority(), 16'($urandom)));
            end
            phase++;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d requests: %0d inserted, %0d refused when full,",
                 requests_sent, n_inserted, n_refused);
        $display("%0d removed, %0d removes on empty, highest fill %0d of %0d",
                 n_removed, n_empty, peak_fill, QDEPTH);
        if (fails == 0)
            $display("PASS sorted_priority_queue");
        else
            $display("FAIL sorted_priority_queue");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("FAIL sorted_priority_queue");
        $finish;
    end

endmodule
